FILE: rtl/core/signed_integer_to_radix_text_core_assert.svh
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_core assertion macros
// shared concurrent assertion forms for the radix text core
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SITR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitr assertion failed");

// next-cycle implication, disabled in reset
`define SITR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitr assertion failed");

`endif

FILE: rtl/core/sitr_pkg.sv
// ----------------------------------------------------------------------------
// sitr_pkg
// shared types, constants and helpers of the radix text core
// ----------------------------------------------------------------------------
package sitr_pkg;

    localparam int MAX_RADIX_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DIGIT_SLOTS     = 32;
    localparam int ALPHA_CHARS     = 16;
    localparam int VALUE_W         = 32;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CNT_W           = 6;
    localparam int SLOT_W          = 5;
    localparam int CHAR_W          = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int DIV_BITS        = 8;
    localparam int DIV_STEPS       = VALUE_W / DIV_BITS;
    localparam int STEP_W          = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;

    localparam logic [RADIX_W-1:0]    RADIX_RST      = 5'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] ALPHA_HIGH_RST = 64'h4645444342413938;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX_SIZE = 2'd0,
        CFG_ALPHA_LOW  = 2'd1,
        CFG_ALPHA_HIGH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RADIX_W-1:0]    radix;
        logic [CFG_DATA_W-1:0] alpha_low;
        logic [CFG_DATA_W-1:0] alpha_high;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               bad;
    } t_job;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[idx[2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

FILE: rtl/core/sitr_front.sv
// ----------------------------------------------------------------------------
// sitr_front
// accepts numbers, checks the alphabet, forms magnitude and sign, and
// holds classified jobs in a short queue for the back end
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_core_assert.svh"

module sitr_front #(
    parameter int MAX_RADIX   = sitr_pkg::MAX_RADIX_DEF,
    parameter int QUEUE_DEPTH = sitr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sitr_pkg::t_cfg                     i_cfg,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [sitr_pkg::VALUE_W-1:0] i_number_value,
    output sitr_pkg::t_job                     o_job,
    output logic                               o_job_valid,
    input  logic                               i_job_pop
);
    import sitr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [CHAR_W-1:0] ch [ALPHA_CHARS];
    logic              bad;
    t_job              job_in;
    logic              wr_en;

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;

    // alphabet check
    always_comb begin
        bad = (i_cfg.radix < 5'd2) || (i_cfg.radix > RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ALPHA_CHARS; i++) begin
            ch[i] = alpha_char(i_cfg.alpha_low, i_cfg.alpha_high, DIGIT_W'(i));
        end
        for (int i = 0; i < ALPHA_CHARS; i++) begin
            if (RADIX_W'(i) < i_cfg.radix) begin
                if (ch[i] == CHAR_PLUS || ch[i] == CHAR_MINUS ||
                    ch[i] < PRINT_LOW || ch[i] > PRINT_HIGH) begin
                    bad = 1'b1;
                end
                for (int j = 0; j < ALPHA_CHARS; j++) begin
                    if (j > i && RADIX_W'(j) < i_cfg.radix && ch[j] == ch[i]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        job_in.neg = i_number_value[VALUE_W-1];
        job_in.mag = job_in.neg ? (VALUE_W'(0) - VALUE_W'(i_number_value))
                                : VALUE_W'(i_number_value);
        job_in.bad = bad;
    end

    assign o_full      = (r_count == FULL_CNT);
    assign wr_en       = i_push && !o_full;
    assign o_job_valid = (r_count != CW'(0));
    assign o_job       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == LAST_PTR) ? PW'(0) : r_wr + PW'(1);
        end
        if (i_job_pop) begin
            n_rd = (r_rd == LAST_PTR) ? PW'(0) : r_rd + PW'(1);
        end
        if (wr_en && !i_job_pop) begin
            n_count = r_count + CW'(1);
        end else if (!wr_en && i_job_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= job_in;
        end
    end

    `SITR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `SITR_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_job_pop, r_count != CW'(0))
    `SITR_ASSERT_NXT(a_push_counts, i_clk, i_rst_n, wr_en && !i_job_pop,
                     r_count == $past(r_count) + CW'(1))

endmodule

FILE: rtl/core/sitr_back.sv
// ----------------------------------------------------------------------------
// sitr_back
// divides the magnitude digit by digit into a digit stack, then emits
// sign and alphabet characters, or one invalid marker for a bad alphabet,
// through a one-entry output register
`include "signed_integer_to_radix_text_core_assert.svh"

module sitr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sitr_pkg::t_cfg               i_cfg,
    input  sitr_pkg::t_job               i_job,
    input  logic                         i_job_valid,
    output logic                         o_job_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [sitr_pkg::CHAR_W-1:0]  o_char_code,
    output logic                         o_last_char,
    output logic                         o_alphabet_invalid
);
    import sitr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_EMIT = 5'b01000,
        S_BAD  = 5'b10000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0]  LAST_SLOT = CNT_W'(DIGIT_SLOTS - 1);

    t_state               r_state;
    t_state               n_state;
    logic [VALUE_W-1:0]   r_quo;
    logic [VALUE_W-1:0]   n_quo;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   n_rem;
    logic                 r_neg;
    logic [STEP_W-1:0]    r_step;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIGIT_W-1:0]   r_stack [DIGIT_SLOTS];
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;
    logic                 r_out_bad;

    logic                 slot_free;
    logic                 load_out;
    logic [CHAR_W-1:0]    n_out_char;
    logic                 n_out_last;
    logic                 n_out_bad;
    logic                 digit_done;
    logic                 div_finish;
    logic [SLOT_W-1:0]    rd_slot;
    logic [DIGIT_W-1:0]   rd_digit;

    // several restoring division steps per cycle
    always_comb begin
        logic [RADIX_W-1:0] t;
        logic [RADIX_W-1:0] diff;
        logic               qb;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            t     = {n_rem, n_quo[VALUE_W-1]};
            qb    = (t >= i_cfg.radix);
            diff  = t - i_cfg.radix;
            n_rem = qb ? diff[DIGIT_W-1:0] : t[DIGIT_W-1:0];
            n_quo = {n_quo[VALUE_W-2:0], qb};
        end
    end

    assign slot_free  = !r_out_valid || i_pop;
    assign digit_done = (r_state == S_DIV) && (r_step == LAST_STEP);
    assign div_finish = digit_done && ((n_quo == '0) || (r_cnt == LAST_SLOT));
    assign rd_slot    = r_cnt[SLOT_W-1:0] - SLOT_W'(1);
    assign rd_digit   = r_stack[rd_slot];
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        n_state    = r_state;
        load_out   = 1'b0;
        n_out_char = '0;
        n_out_last = 1'b0;
        n_out_bad  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.bad ? S_BAD : S_DIV;
                end
            end
            S_DIV: begin
                if (div_finish) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_char = CHAR_MINUS;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_char = alpha_char(i_cfg.alpha_low, i_cfg.alpha_high, rd_digit);
                    n_out_last = (r_cnt == CNT_W'(1));
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BAD: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_last = 1'b1;
                    n_out_bad  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_job_pop) begin
                r_cnt  <= '0;
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + STEP_W'(1);
                if (digit_done) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (r_state == S_EMIT && slot_free) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_quo <= i_job.mag;
            r_neg <= i_job.neg;
            r_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= n_quo;
            r_rem <= digit_done ? '0 : n_rem;
        end
        if (digit_done) begin
            r_stack[r_cnt[SLOT_W-1:0]] <= n_rem;
        end
        if (load_out) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_char_code        = r_out_char;
    assign o_last_char        = r_out_last;
    assign o_alphabet_invalid = r_out_bad;

    `SITR_ASSERT_IMP(a_bad_is_last, i_clk, i_rst_n, r_out_valid && r_out_bad, r_out_last)
    `SITR_ASSERT_IMP(a_emit_has_digit, i_clk, i_rst_n, r_state == S_EMIT, r_cnt != '0)
    `SITR_ASSERT_NXT(a_finish_leaves_div, i_clk, i_rst_n, div_finish,
                     r_state == S_SIGN || r_state == S_EMIT)

endmodule

FILE: rtl/core/signed_integer_to_radix_text_core.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_core
// prints signed 32-bit numbers as text in a configurable radix
// ----------------------------------------------------------------------------
// Numbers enter through a queue-like port: an item is taken when push is high
// and full is low. Characters leave the same way: the oldest one is shown
// while empty is low and is taken when pop is high. Each number gives an
// optional '-' and its digits, most significant first, with o_last_char on
// the final character; a bad alphabet gives one character with
// o_alphabet_invalid set.
// The back end divides by the radix eight quotient bits per cycle, storing
// each digit on a digit stack; it then emits the sign and the digits one
// character per cycle while the receiver keeps popping. It takes the next
// number from the queue only once the last character of the current one is
// loaded into the output register.
// The front queue takes new numbers while the back end works; a stalled
// receiver holds the back end, and once the queue fills, full is raised.
// Reset empties the queue and the output and restores radix 10 with the
// alphabet "0123456789ABCDEF". Configuration writes land at once.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_core #(
    parameter int MAX_RADIX   = sitr_pkg::MAX_RADIX_DEF,
    parameter int QUEUE_DEPTH = sitr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sitr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sitr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sitr_pkg::VALUE_W-1:0] i_number_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [sitr_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_last_char,
    output logic                                o_alphabet_invalid
);
    import sitr_pkg::*;

    t_cfg r_cfg;
    t_job job;
    logic job_valid;
    logic job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix      <= RADIX_RST;
            r_cfg.alpha_low  <= ALPHA_LOW_RST;
            r_cfg.alpha_high <= ALPHA_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIX_SIZE: r_cfg.radix      <= i_cfg_data[RADIX_W-1:0];
                CFG_ALPHA_LOW:  r_cfg.alpha_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_cfg.alpha_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sitr_front #(
        .MAX_RADIX   (MAX_RADIX),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_full         (full),
        .i_number_value (i_number_value),
        .o_job          (job),
        .o_job_valid    (job_valid),
        .i_job_pop      (job_pop)
    );

    sitr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_job              (job),
        .i_job_valid        (job_valid),
        .o_job_pop          (job_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_char_code        (o_char_code),
        .o_last_char        (o_last_char),
        .o_alphabet_invalid (o_alphabet_invalid)
    );

endmodule

FILE: verif/signed_integer_to_radix_text_core_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_core_tb
// self-checking bench for the radix text core: numbers go in through the
// push side, characters are predicted per accepted item and checked in order
// as they are popped, across default, edge, broken and random alphabets
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_core_tb;
    import sitr_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 5;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES      = 400;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 48;
    localparam int PRESSURE_ITEMS   = 12;
    localparam int ALPHA_W          = 2 * CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [ALPHA_W-1:0]   DECIMAL_ALPHA = {ALPHA_HIGH_RST, ALPHA_LOW_RST};

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              invalid;
    } t_text_char;

    typedef enum {POP_STEADY, POP_COIN, POP_SPARSE, POP_MOSTLY} t_pop_mode;
    typedef enum {SPOIL_PLUS, SPOIL_MINUS, SPOIL_LOW, SPOIL_HIGH, SPOIL_REPEAT} t_spoil_kind;
    typedef enum {SHAPE_WIDE, SHAPE_SHORT, SHAPE_EXTREME, SHAPE_POWER} t_number_shape;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      push;
    logic                      full;
    logic signed [VALUE_W-1:0] i_number_value;
    logic                      empty;
    logic                      pop;
    logic [CHAR_W-1:0]         o_char_code;
    logic                      o_last_char;
    logic                      o_alphabet_invalid;

    logic [RADIX_W-1:0] radix_shadow;
    logic [ALPHA_W-1:0] alphabet_shadow;

    t_text_char  chars_due[$];
    int unsigned numbers_taken   = 0;
    int unsigned chars_checked   = 0;
    int unsigned invalid_results = 0;
    int unsigned blocked_offers  = 0;
    int unsigned mismatches      = 0;
    int          burst_left      = 0;
    bit          hold_request    = 1'b0;

    signed_integer_to_radix_text_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .push               (push),
        .full               (full),
        .i_number_value     (i_number_value),
        .empty              (empty),
        .pop                (pop),
        .o_char_code        (o_char_code),
        .o_last_char        (o_last_char),
        .o_alphabet_invalid (o_alphabet_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge i_clk);
        $display("FAIL signed_integer_to_radix_text_core");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] digit_glyph(input int unsigned idx);
        return alphabet_shadow[idx*CHAR_W +: CHAR_W];
    endfunction

    function automatic bit alphabet_usable();
        logic [CHAR_W-1:0] c;
        if (radix_shadow < 2 || radix_shadow > MAX_RADIX_DEF)
            return 1'b0;
        for (int i = 0; i < radix_shadow; i++) begin
            c = digit_glyph(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS || c < PRINT_LOW || c > PRINT_HIGH)
                return 1'b0;
            for (int j = i + 1; j < radix_shadow; j++)
                if (digit_glyph(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_radix_text(input logic [VALUE_W-1:0] raw);
        logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
        logic [VALUE_W-1:0] mag;
        int unsigned        n;
        if (!alphabet_usable()) begin
            chars_due.push_back(t_text_char'{'0, 1'b1, 1'b1});
            return;
        end
        mag = raw[VALUE_W-1] ? -raw : raw;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(mag % radix_shadow);
            mag = mag / radix_shadow;
            n++;
        end while (mag != 0 && n < DIGIT_SLOTS);
        if (raw[VALUE_W-1])
            chars_due.push_back(t_text_char'{CHAR_MINUS, 1'b0, 1'b0});
        while (n > 0) begin
            n--;
            chars_due.push_back(t_text_char'{digit_glyph(digits[n]), n == 0, 1'b0});
        end
    endfunction

    // accepted items feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && push) begin
            if (full) begin
                blocked_offers++;
            end else begin
                numbers_taken++;
                predict_radix_text(i_number_value);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_text_char seen;
        t_text_char want;
        if (i_rst_n && pop && !empty) begin
            seen = t_text_char'{o_char_code, o_last_char, o_alphabet_invalid};
            chars_checked++;
            if (seen.invalid)
                invalid_results++;
            if (chars_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected char %h last %b invalid %b", $time,
                             seen.code, seen.last, seen.invalid);
            end else begin
                want = chars_due.pop_front();
                if (seen.code !== want.code || seen.last !== want.last ||
                    seen.invalid !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: expected char %h last %b invalid %b, got %h %b %b",
                                 $time, want.code, want.last, want.invalid,
                                 seen.code, seen.last, seen.invalid);
                end
            end
        end
    end

    initial begin : receiver
        t_pop_mode mode;
        int        mode_left;
        int        stall_left;
        mode = POP_STEADY;
        mode_left = 0;
        stall_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode = t_pop_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    POP_STEADY: pop <= 1'b1;
                    POP_COIN:   pop <= ($urandom_range(0, 1) == 1);
                    POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                    default:    pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_number(input logic [VALUE_W-1:0] value);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        push <= 1'b1;
        i_number_value <= value;
        do @(posedge i_clk); while (full);
    endtask

    task automatic wait_all_delivered();
        push <= 1'b0;
        do @(posedge i_clk); while (chars_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RADIX_SIZE: radix_shadow = data[RADIX_W-1:0];
            CFG_ALPHA_LOW:  alphabet_shadow[CFG_DATA_W-1:0] = data;
            CFG_ALPHA_HIGH: alphabet_shadow[ALPHA_W-1:CFG_DATA_W] = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // upper bits of the radix word are junk and must be dropped
    function automatic logic [CFG_DATA_W-1:0] radix_word(input int radix);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom, $urandom};
        w[RADIX_W-1:0] = RADIX_W'(radix);
        return w;
    endfunction

    function automatic logic [ALPHA_W-1:0] with_glyph(input logic [ALPHA_W-1:0] chars,
                                                      input int pos,
                                                      input logic [CHAR_W-1:0] c);
        chars[pos*CHAR_W +: CHAR_W] = c;
        return chars;
    endfunction

    task automatic load_alphabet(input int radix, input logic [ALPHA_W-1:0] chars);
        wait_all_delivered();
        write_reg(CFG_RADIX_SIZE, radix_word(radix));
        write_reg(CFG_ALPHA_LOW, chars[CFG_DATA_W-1:0]);
        write_reg(CFG_ALPHA_HIGH, chars[ALPHA_W-1:CFG_DATA_W]);
    endtask

    function automatic logic [ALPHA_W-1:0] random_alphabet(input int radix);
        logic [ALPHA_W-1:0] chars;
        bit                 taken [256];
        logic [CHAR_W-1:0]  c;
        chars = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < radix; i++) begin
            do c = CHAR_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
            while (c == CHAR_PLUS || c == CHAR_MINUS || taken[c]);
            taken[c] = 1'b1;
            chars[i*CHAR_W +: CHAR_W] = c;
        end
        return chars;
    endfunction

    function automatic logic [ALPHA_W-1:0] spoil_alphabet(input logic [ALPHA_W-1:0] chars,
                                                          input int radix);
        int pos;
        int other;
        pos = $urandom_range(0, radix - 1);
        other = (pos + $urandom_range(1, radix - 1)) % radix;
        case (t_spoil_kind'($urandom_range(0, 4)))
            SPOIL_PLUS:  return with_glyph(chars, pos, CHAR_PLUS);
            SPOIL_MINUS: return with_glyph(chars, pos, CHAR_MINUS);
            SPOIL_LOW:   return with_glyph(chars, pos, CHAR_W'($urandom_range(0, 31)));
            SPOIL_HIGH:  return with_glyph(chars, pos, CHAR_W'($urandom_range(127, 255)));
            default:     return with_glyph(chars, pos, chars[other*CHAR_W +: CHAR_W]);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_number(input int radix);
        logic [VALUE_W-1:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1};
        logic [VALUE_W-1:0] v;
        t_number_shape      shape;
        int                 steps;
        shape = ($urandom_range(0, 7) < 3) ? SHAPE_WIDE
                                           : t_number_shape'($urandom_range(1, 3));
        case (shape)
            SHAPE_WIDE:    v = $urandom;
            SHAPE_SHORT:   v = $urandom >> $urandom_range(1, 31);
            SHAPE_EXTREME: v = extremes[$urandom_range(0, 3)];
            default: begin
                v = 1;
                steps = $urandom_range(0, 31);
                while (steps > 0 && v <= 32'hFFFF_FFFF / radix) begin
                    v = v * radix;
                    steps--;
                end
                v = v - $urandom_range(0, 1);
            end
        endcase
        if (shape != SHAPE_WIDE && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    task automatic test_default_decimal();
        // the spare index must leave every register alone
        write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
        send_number(32'd0);
        send_number(32'd1);
        send_number(-32'sd1);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(-32'sd10);
        send_number(32'd1234567890);
    endtask

    task automatic test_radix_extremes();
        load_alphabet(2, DECIMAL_ALPHA);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd0);
        // printable range ends, sixteen distinct glyphs
        load_alphabet(MAX_RADIX_DEF, {64'h302F_2E2C_2A29_2821, 64'h2726_2524_2322_7E20});
        send_number(-32'sd1);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        // illegal glyphs beyond the radix do not count
        load_alphabet(3, with_glyph(with_glyph(DECIMAL_ALPHA, 5, CHAR_PLUS), 15, 8'h00));
        send_number(-32'sd7);
    endtask

    task automatic check_bad_alphabet(input int radix, input logic [ALPHA_W-1:0] chars);
        load_alphabet(radix, chars);
        send_number($urandom);
    endtask

    task automatic test_bad_alphabets();
        check_bad_alphabet(0, DECIMAL_ALPHA);
        check_bad_alphabet(1, DECIMAL_ALPHA);
        check_bad_alphabet(MAX_RADIX_DEF + 1, DECIMAL_ALPHA);
        check_bad_alphabet(31, DECIMAL_ALPHA);
        check_bad_alphabet(10, with_glyph(DECIMAL_ALPHA, 3, CHAR_PLUS));
        check_bad_alphabet(10, with_glyph(DECIMAL_ALPHA, 9, CHAR_MINUS));
        check_bad_alphabet(16, with_glyph(DECIMAL_ALPHA, 15, 8'h1F));
        check_bad_alphabet(12, with_glyph(DECIMAL_ALPHA, 0, 8'h7F));
        check_bad_alphabet(2, with_glyph(DECIMAL_ALPHA, 1, 8'h00));
        check_bad_alphabet(9, with_glyph(DECIMAL_ALPHA, 4, 8'h80));
        check_bad_alphabet(16, with_glyph(DECIMAL_ALPHA, 8, 8'hFF));
        check_bad_alphabet(16, with_glyph(DECIMAL_ALPHA, 15, DECIMAL_ALPHA[CHAR_W-1:0]));
    endtask

    task automatic test_random_numbers();
        logic [ALPHA_W-1:0] chars;
        int                 radix;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                radix = 2;
            else if (phase == 1)
                radix = MAX_RADIX_DEF;
            else
                radix = $urandom_range(2, MAX_RADIX_DEF);
            chars = random_alphabet(radix);
            if (phase % 5 == 4)
                chars = spoil_alphabet(chars, radix);
            load_alphabet(radix, chars);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_number(random_number(radix));
        end
    endtask

    task automatic test_output_backpressure();
        load_alphabet(2, DECIMAL_ALPHA);
        hold_request = 1'b1;
        burst_left = PRESSURE_ITEMS;
        for (int k = 0; k < PRESSURE_ITEMS; k++)
            send_number($urandom);
        wait_all_delivered();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_RADIX_SIZE;
        i_cfg_data <= '0;
        push <= 1'b0;
        i_number_value <= '0;
        radix_shadow = RADIX_RST;
        alphabet_shadow = DECIMAL_ALPHA;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_decimal();
        test_radix_extremes();
        test_bad_alphabets();
        test_random_numbers();
        test_output_backpressure();

        wait_all_delivered();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d numbers as %0d characters, %0d alphabet rejects",
                 numbers_taken, chars_checked, invalid_results);
        $display("radix 0 to 31 settings, %0d offers held off by full, %0d mismatches",
                 blocked_offers, mismatches);
        if (mismatches == 0)
            $display("PASS signed_integer_to_radix_text_core");
        else
            $display("FAIL signed_integer_to_radix_text_core");
        $finish;
    end

endmodule
